// File: sv/ifmt_pkg.sv
// Shared types, constants and helpers for the integer field formatter.
package ifmt_pkg;

	// Default saturation limits and the pointer default width
	localparam int MAX_WIDTH_DEF     = 48;
	localparam int MAX_PREC_DEF      = 48;
	localparam int PTR_DEFAULT_WIDTH = 18;

	// Operand, field and counter widths
	localparam int VAL_W  = 64;
	localparam int FLD_W  = 6;
	localparam int CNT_W  = 7;   // holds any field length up to 2 * 60 + 3
	localparam int ND_W   = 5;

	// Digit store: 22 nibbles covers 64-bit octal; decimal uses 20 BCD digits
	localparam int DIG_N  = 22;
	localparam int DIG_W  = 4 * DIG_N;
	localparam int BCD_N  = 20;
	localparam int BCD_W  = 4 * BCD_N;

	// Stream widths
	localparam int IN_TDATA_W  = 88;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 8;

	// Conversion kinds carried in tuser
	localparam logic [2:0] CMD_SDEC = 3'd0;
	localparam logic [2:0] CMD_UDEC = 3'd1;
	localparam logic [2:0] CMD_OCT  = 3'd2;
	localparam logic [2:0] CMD_HEXL = 3'd3;
	localparam logic [2:0] CMD_HEXU = 3'd4;
	localparam logic [2:0] CMD_PTR  = 3'd5;

	// ASCII codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_A_UP  = 8'h41;

	typedef enum logic [1:0] {
		KIND_DEC,
		KIND_OCT,
		KIND_HEX
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WAIT_DEC,
		ST_NORM,
		ST_PLAN,
		ST_LEAD,
		ST_PRE,
		ST_ZERO,
		ST_DIG,
		ST_TRAIL
	} state_t;

	// One digit value to its ASCII character
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base_ch;
		base_ch = upper ? CH_A_UP : CH_A_LO;
		if (d < 4'd10)
			digit_char = CH_ZERO + {4'd0, d};
		else
			digit_char = base_ch + {4'd0, d} - 8'd10;
	endfunction

endpackage

// File: sv/ifmt_dec_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one operand bit per cycle.
module ifmt_dec_conv (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ifmt_pkg::VAL_W-1:0] value,
	output logic [ifmt_pkg::BCD_W-1:0] bcd,
	output logic                      done
);
	import ifmt_pkg::*;

	localparam int STEP_W = $clog2(VAL_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [VAL_W-1:0]  sh_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  adj;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < BCD_N; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Data: operand shifts out MSB first into the BCD register
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[VAL_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], sh_q[VAL_W-1]};
		end
	end

	assign bcd  = bcd_q;
	assign done = done_q;

endmodule

// File: sv/integer_field_formatter_core.sv
// Top level of the integer field formatter: printf-style integer fields as a character stream.
//
// Input channel s_*: one item per transfer; s_tuser carries the conversion kind and
// s_tdata the operand and format fields. Output channel m_*: one ASCII character per
// transfer in m_tdata, with m_tlast on the final character of the field.
// One item is handled at a time; s_tready is high only between items.
// Steps per item: accept and load, then for decimal kinds the bit-serial BCD converter
// (one operand bit a cycle), then leading-zero trimming (one digit a cycle), a planning
// step, then one character per cycle while m_tready allows it, with a turnover step as
// each segment (lead, prefix, zeros, digits, trail) ends.
// The output register lets the last character wait while the next item is accepted.
// A stall on m_tready holds the current character and pauses emission; nothing is lost.
// Reset (arst_n low) empties the output register and returns the block to idle.
module integer_field_formatter_core #(
	parameter int MAX_WIDTH     = ifmt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_PRECISION = ifmt_pkg::MAX_PREC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata from bit 0: value[63:0], size_code[65:64], left_align[66], force_plus[67],
	// space_sign[68], zero_fill[69], alternate[70], width[76:71], precision[82:77],
	// has_precision[83], zero fill [87:84]
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ifmt_pkg::IN_TDATA_W-1:0]  s_tdata,
	// s_tuser from bit 0: cmd[2:0]
	input  logic [ifmt_pkg::IN_TUSER_W-1:0]  s_tuser,
	// m_tdata from bit 0: out_char[7:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ifmt_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast
);
	import ifmt_pkg::*;

	// Input field views
	logic [VAL_W-1:0] in_value;
	logic [1:0]       in_size;
	logic             in_left, in_plus, in_space, in_zero, in_alt, in_has_prec;
	logic [FLD_W-1:0] in_width, in_prec;

	assign in_value    = s_tdata[63:0];
	assign in_size     = s_tdata[65:64];
	assign in_left     = s_tdata[66];
	assign in_plus     = s_tdata[67];
	assign in_space    = s_tdata[68];
	assign in_zero     = s_tdata[69];
	assign in_alt      = s_tdata[70];
	assign in_width    = s_tdata[76:71];
	assign in_prec     = s_tdata[82:77];
	assign in_has_prec = s_tdata[83];

	state_t state_q, state_d;

	// Item registers
	kind_t            kind_q;
	logic             sdec_q, neg_q, upper_q, alt_q, mag_zero_q;
	logic             left_q, plus_q, space_q, zero_q, has_prec_q;
	logic [FLD_W-1:0] width_q, prec_q;
	logic [VAL_W-1:0] mag_q;
	logic [DIG_W-1:0] dig_q;

	// Emission counters
	logic [ND_W-1:0]  nd_q;
	logic [1:0]       npre_q;
	logic [7:0]       pre0_q, pre1_q;
	logic [CNT_W-1:0] lead_q, zcnt_q, trail_q, total_q;

	// Output register
	logic                   m_tvalid_q, m_tlast_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// Decoded input item
	kind_t            a_kind;
	logic             a_sdec, a_upper, a_alt, a_sbit, a_neg;
	logic [VAL_W-1:0] a_mask, a_masked, a_mag;
	logic [FLD_W-1:0] a_width, a_prec;

	always_comb begin
		a_sdec  = 1'b0;
		a_upper = 1'b0;
		a_alt   = in_alt;
		a_kind  = KIND_DEC;
		case (s_tuser)
			CMD_SDEC: a_sdec = 1'b1;
			CMD_OCT:  a_kind = KIND_OCT;
			CMD_HEXL: a_kind = KIND_HEX;
			CMD_HEXU: begin
				a_kind  = KIND_HEX;
				a_upper = 1'b1;
			end
			CMD_PTR: begin
				a_kind = KIND_HEX;
				a_alt  = 1'b1;
			end
			default: a_kind = KIND_DEC;
		endcase

		case (in_size)
			2'd0: begin
				a_mask = VAL_W'(64'hFF);
				a_sbit = in_value[7];
			end
			2'd1: begin
				a_mask = VAL_W'(64'hFFFF);
				a_sbit = in_value[15];
			end
			2'd2: begin
				a_mask = VAL_W'(64'hFFFF_FFFF);
				a_sbit = in_value[31];
			end
			default: begin
				a_mask = '1;
				a_sbit = in_value[63];
			end
		endcase
		if (s_tuser == CMD_PTR)
			a_mask = '1;

		a_masked = in_value & a_mask;
		a_neg    = a_sdec && a_sbit;
		a_mag    = a_neg ? ((VAL_W'(0) - a_masked) & a_mask) : a_masked;

		// Saturate width and precision; pointers default their width
		a_width = (int'(in_width) > MAX_WIDTH) ? FLD_W'(MAX_WIDTH) : in_width;
		a_prec  = (int'(in_prec) > MAX_PRECISION) ? FLD_W'(MAX_PRECISION) : in_prec;
		if (s_tuser == CMD_PTR && in_width == '0)
			a_width = (PTR_DEFAULT_WIDTH > MAX_WIDTH) ? FLD_W'(MAX_WIDTH)
			                                           : FLD_W'(PTR_DEFAULT_WIDTH);
	end

	// Decimal conversion unit
	logic             dec_start, dec_done;
	logic [BCD_W-1:0] dec_bcd;

	ifmt_dec_conv u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dec_start),
		.value  (mag_q),
		.bcd    (dec_bcd),
		.done   (dec_done)
	);

	// Octal digits straight from the operand bits, three to a nibble
	logic [VAL_W+1:0] mag_ext;
	logic [DIG_W-1:0] oct_dig, hex_dig;

	always_comb begin
		mag_ext = {2'b00, mag_q};
		for (int i = 0; i < DIG_N; i++)
			oct_dig[4*i +: 4] = {1'b0, mag_ext[3*i +: 3]};
		hex_dig = {{(DIG_W-VAL_W){1'b0}}, mag_q};
	end

	logic [3:0] top_dig;
	assign top_dig = dig_q[DIG_W-1 -: 4];

	// Field plan: prefix, precision zeros, padding
	logic [CNT_W-1:0] p_nd, p_prec, p_width, p_zpad, p_payload, p_pad;
	logic [1:0]       p_npre;
	logic [7:0]       p_pre0, p_pre1;
	logic             p_zero_pad;

	always_comb begin
		p_nd    = CNT_W'(nd_q);
		p_prec  = CNT_W'(prec_q);
		p_width = CNT_W'(width_q);
		p_zpad  = (has_prec_q && p_prec > p_nd) ? p_prec - p_nd : '0;
		p_npre  = 2'd0;
		p_pre0  = CH_ZERO;
		p_pre1  = upper_q ? CH_X_UP : CH_X_LO;
		if (sdec_q) begin
			if (neg_q) begin
				p_npre = 2'd1;
				p_pre0 = CH_MINUS;
			end else if (plus_q) begin
				p_npre = 2'd1;
				p_pre0 = CH_PLUS;
			end else if (space_q) begin
				p_npre = 2'd1;
				p_pre0 = CH_SPACE;
			end
		end else if (alt_q && !mag_zero_q) begin
			if (kind_q == KIND_HEX)
				p_npre = 2'd2;
			else if (kind_q == KIND_OCT && p_zpad == '0)
				p_npre = 2'd1;
		end
		p_payload  = CNT_W'(p_npre) + p_zpad + p_nd;
		p_pad      = (p_width > p_payload) ? p_width - p_payload : '0;
		p_zero_pad = zero_q && !has_prec_q && !left_q;
	end

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = ST_LOAD;
			ST_LOAD:     state_d = (kind_q == KIND_DEC) ? ST_WAIT_DEC : ST_NORM;
			ST_WAIT_DEC: if (dec_done) state_d = ST_NORM;
			ST_NORM:     if (top_dig != 4'd0 || nd_q == ND_W'(1)) state_d = ST_PLAN;
			ST_PLAN:     state_d = ST_LEAD;
			ST_LEAD:     if (lead_q == '0) state_d = ST_PRE;
			ST_PRE:      if (npre_q == 2'd0) state_d = ST_ZERO;
			ST_ZERO:     if (zcnt_q == '0) state_d = ST_DIG;
			ST_DIG:      if (nd_q == '0) state_d = ST_TRAIL;
			ST_TRAIL:    if (trail_q == '0) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// State outputs: handshake, converter start, character select
	logic       seg_active;
	logic [7:0] sel_char;
	logic       emit_go;

	always_comb begin
		s_tready   = 1'b0;
		dec_start  = 1'b0;
		seg_active = 1'b0;
		sel_char   = CH_SPACE;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_LOAD: dec_start = (kind_q == KIND_DEC);
			ST_LEAD: seg_active = (lead_q != '0);
			ST_PRE: begin
				seg_active = (npre_q != 2'd0);
				sel_char   = pre0_q;
			end
			ST_ZERO: begin
				seg_active = (zcnt_q != '0);
				sel_char   = CH_ZERO;
			end
			ST_DIG: begin
				seg_active = (nd_q != '0);
				sel_char   = digit_char(top_dig, upper_q);
			end
			ST_TRAIL: seg_active = (trail_q != '0);
			default: s_tready = 1'b0;
		endcase
	end

	assign emit_go = seg_active && out_free;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			nd_q       <= '0;
			npre_q     <= 2'd0;
			lead_q     <= '0;
			zcnt_q     <= '0;
			trail_q    <= '0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Digit count: full store on load, trimmed, then counted out
			if ((state_q == ST_LOAD && kind_q != KIND_DEC) ||
			    (state_q == ST_WAIT_DEC && dec_done))
				nd_q <= ND_W'(DIG_N);
			else if (state_q == ST_NORM && state_d == ST_NORM)
				nd_q <= nd_q - 1'b1;
			else if (state_q == ST_DIG && emit_go)
				nd_q <= nd_q - 1'b1;

			if (state_q == ST_PLAN) begin
				npre_q  <= p_npre;
				lead_q  <= (!left_q && !p_zero_pad) ? p_pad : '0;
				zcnt_q  <= p_zero_pad ? p_pad + p_zpad : p_zpad;
				trail_q <= left_q ? p_pad : '0;
				total_q <= p_payload + p_pad;
			end else if (emit_go) begin
				total_q <= total_q - 1'b1;
				case (state_q)
					ST_LEAD:  lead_q  <= lead_q - 1'b1;
					ST_PRE:   npre_q  <= npre_q - 1'b1;
					ST_ZERO:  zcnt_q  <= zcnt_q - 1'b1;
					ST_TRAIL: trail_q <= trail_q - 1'b1;
					default:  ;
				endcase
			end

			// Output register valid
			if (emit_go)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q     <= a_kind;
			sdec_q     <= a_sdec;
			neg_q      <= a_neg;
			upper_q    <= a_upper;
			alt_q      <= a_alt;
			mag_q      <= a_mag;
			mag_zero_q <= (a_masked == '0);
			left_q     <= in_left;
			plus_q     <= in_plus;
			space_q    <= in_space;
			zero_q     <= in_zero;
			has_prec_q <= in_has_prec;
			width_q    <= a_width;
			prec_q     <= a_prec;
		end

		// Digit store: load, trim leading zeros, shift out MSB first
		if (state_q == ST_LOAD && kind_q != KIND_DEC)
			dig_q <= (kind_q == KIND_OCT) ? oct_dig : hex_dig;
		else if (state_q == ST_WAIT_DEC && dec_done)
			dig_q <= {{(DIG_W-BCD_W){1'b0}}, dec_bcd};
		else if ((state_q == ST_NORM && state_d == ST_NORM) ||
		         (state_q == ST_DIG && emit_go))
			dig_q <= {dig_q[DIG_W-5:0], 4'd0};

		if (state_q == ST_PLAN) begin
			pre0_q <= p_pre0;
			pre1_q <= p_pre1;
		end else if (state_q == ST_PRE && emit_go) begin
			pre0_q <= pre1_q;
		end

		if (emit_go) begin
			m_tdata_q <= sel_char;
			m_tlast_q <= (total_q == CNT_W'(1));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef ASSERT_OFF
	// Every planned character has gone out by the time the block is idle again
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> total_q == '0)
		else $error("field ended with characters still planned");

	// Trimming never removes the last digit
	a_norm_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NORM |-> nd_q != '0)
		else $error("digit count reached zero while trimming");

	// No character is issued beyond the planned field length
	a_emit_planned: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |-> total_q != '0)
		else $error("character issued beyond field length");

	// Decimal digits leaving the store are proper BCD
	a_bcd_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIG && nd_q != '0 && kind_q == KIND_DEC) |-> top_dig <= 4'd9)
		else $error("decimal digit out of range");
`endif

endmodule
